/* hdl/scsa_pkg.sv */
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, codes and constants of the sigma-clipped sensor averager.
// ----------------------------------------------------------------------------
`default_nettype none

package scsa_pkg;

   // default samples per reading
   localparam int SamplesDefault = 16;

   // widths fixed by the item and register fields
   localparam int XW        = 18;
   localparam int TW        = 26;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 18;

   // register reset values
   localparam logic signed [15:0] OffsetReset   = 16'sd0;
   localparam logic [11:0]        SigmaReset    = 12'd282;
   localparam logic [15:0]        MaxDevReset   = 16'd64;
   localparam logic signed [17:0] DiscReset     = 18'sd400;
   localparam logic signed [17:0] NoPowerReset  = -18'sd2;
   localparam logic signed [TW-1:0] TempReset   = -26'sd69926;

   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_START     = 2'd1,
      OP_POWER_ON  = 2'd2,
      OP_POWER_OFF = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OFF      = 2'd0,
      STS_NO_DATA  = 2'd1,
      STS_HAS_DATA = 2'd2,
      STS_ERROR    = 2'd3
   } sts_type;

   typedef enum logic [2:0] {
      RC_IDLE         = 3'd0,
      RC_TAKING       = 3'd1,
      RC_BAD          = 3'd2,
      RC_DISCONNECTED = 3'd3,
      RC_NO_POWER     = 3'd4
   } code_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_OFFSET   = 3'd0,
      CSR_SIGMA    = 3'd1,
      CSR_MAX_DEV  = 3'd2,
      CSR_DISC     = 3'd3,
      CSR_NO_POWER = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SUM_RD,
      BK_SUM_SQ,
      BK_SUM_ACC,
      BK_VAR_A,
      BK_VAR_B,
      BK_BAD_CHK,
      BK_KV_LO,
      BK_KV_HI,
      BK_KEEP_RD,
      BK_KEEP_DEV,
      BK_KEEP_SQ,
      BK_KEEP_CMP,
      BK_AVG,
      BK_DIV,
      BK_DONE
   } bk_state_type;

   // classified item between front and back
   typedef struct packed {
      op_type                op;
      logic signed [XW-1:0]  x;
   } item_type;

   // result item
   typedef struct packed {
      sts_type               status;
      code_type              code;
      logic signed [TW-1:0]  temp;
      logic                  done;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/scsa_front.sv */
// ----------------------------------------------------------------------------
// scsa_front
// Accepts items, applies the sample offset and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scsa_front import scsa_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [1:0]          req_operation,
   input  wire logic [15:0]         req_adc_sample,
   input  wire logic signed [15:0]  offset,
   output logic                     item_valid,
   output item_type                 item,
   input  wire logic                item_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push_c;
   logic       pop_c;
   item_type   new_c;

   // offset the raw sample
   always_comb begin
      new_c.op = op_type'(req_operation);
      new_c.x  = signed'({2'b00, req_adc_sample}) + XW'(offset);
   end

   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push_c     = req_push && !req_full;
   assign pop_c      = item_pop && item_valid;

   // queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push_c) wr_ptr_ff <= !wr_ptr_ff;
         if (pop_c)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push_c} - {1'b0, pop_c};
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_c) slot_ff[wr_ptr_ff] <= new_c;
   end

endmodule

`default_nettype wire

/* hdl/scsa_div.sv */
// ----------------------------------------------------------------------------
// scsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scsa_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  mag,
   input  wire logic [DEN_W-1:0]  den,
   output logic                   done,
   output logic [NUM_W-1:0]       quo
);

   localparam int StepW = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [StepW-1:0] step_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_sh_c;
   logic [DEN_W:0]   rem_dif_c;
   logic             fits_c;
   logic [DEN_W-1:0] rem_in;

   // one trial subtraction
   always_comb begin
      rem_sh_c  = {rem_ff, quo_ff[NUM_W-1]};
      fits_c    = (rem_sh_c >= {1'b0, den_ff});
      rem_dif_c = fits_c ? (rem_sh_c - {1'b0, den_ff}) : rem_sh_c;
      rem_in    = rem_dif_c[DEN_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= StepW'(NUM_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == StepW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= mag;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits_c};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

/* hdl/scsa_back.sv */
// ----------------------------------------------------------------------------
// scsa_back
// Sensor state, sample store and the sigma-clipped reading sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module scsa_back import scsa_pkg::*; #(
   parameter int SAMPLES = SamplesDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire item_type            item,
   output logic                     item_pop,
   input  wire logic                rsp_space,
   output logic                     rsp_push,
   output rsp_type                  rsp,
   input  wire logic [11:0]         sigma_scale,
   input  wire logic [15:0]         max_dev,
   input  wire logic signed [17:0]  disc_thr,
   input  wire logic signed [17:0]  np_thr
);

   localparam int LN    = $clog2(SAMPLES);
   localparam int AddrW = LN;
   localparam int CntW  = $clog2(SAMPLES + 1);
   localparam int NW    = CntW;
   localparam int SW    = XW + LN;
   localparam int QW    = 2 * XW - 1 + LN;
   localparam int NQW   = QW + NW;
   localparam int VW    = NQW + 1;
   localparam int DVW   = XW + NW + 1;
   localparam int N2W   = 2 * NW;
   localparam int DNW   = 32 + N2W;
   localparam int KVW   = 24 + VW;
   localparam int VHW   = VW - 24;
   localparam int BW    = (VW + 8 > DNW) ? VW + 8 : DNW;
   localparam int CMPW  = (2 * DVW + 16 > KVW) ? 2 * DVW + 16 : KVW;
   localparam int AVW   = SW + 11;
   localparam int DenW  = NW + 1;

   localparam logic [NW-1:0]    NConst  = NW'(SAMPLES);
   localparam logic [N2W-1:0]   N2Const = N2W'(SAMPLES * SAMPLES);
   localparam logic [AddrW-1:0] LastIdx = AddrW'(SAMPLES - 1);

   bk_state_type state_ff, state_in;

   // sample store
   logic signed [XW-1:0] store_ff [SAMPLES];
   logic signed [XW-1:0] rd_ff;

   // sensor state
   logic [CntW-1:0]      cnt_ff, cnt_in;
   sts_type              sts_ff, sts_in;
   code_type             code_ff, code_in;
   logic signed [TW-1:0] temp_ff, temp_in;

   // reading datapath
   logic [AddrW-1:0]       idx_ff;
   logic signed [SW-1:0]   s_ff;
   logic [QW-1:0]          q_ff;
   logic signed [2*XW-1:0] sq_ff;
   logic signed [2*SW-1:0] ss_ff;
   logic [NQW-1:0]         nq_ff;
   logic [31:0]            d2_ff;
   logic [23:0]            k2_ff;
   logic [VW-1:0]          v_ff;
   logic [DNW-1:0]         dn_ff;
   logic [47:0]            kvlo_ff;
   logic [KVW-1:0]         kv_ff;
   logic [DVW-1:0]         ad_ff;
   logic [2*DVW-1:0]       ad2_ff;
   logic signed [SW-1:0]   ksum_ff;
   logic [CntW-1:0]        kcnt_ff;
   logic                   neg_ff;

   logic                   fire_c;
   logic                   take_c;
   logic                   last_c;
   logic                   wr_c;
   logic                   bad_c;
   logic                   keep_c;
   logic signed [VW-1:0]   v_raw_c;
   logic signed [DVW-1:0]  nx_c;
   logic signed [DVW-1:0]  dev_c;
   logic [DVW-1:0]         ad_c;
   logic [VW-1:0]          kh_c;
   logic signed [SW-1:0]   avg_sum_c;
   logic [CntW-1:0]        avg_cnt_c;
   logic signed [AVW-1:0]  num_c;
   logic [AVW-1:0]         mag_c;
   logic [DenW-1:0]        den_c;
   logic                   div_start_c;
   logic                   div_done;
   logic [AVW-1:0]         div_quo;
   logic signed [TW-1:0]   t_c;
   logic signed [TW-1:0]   disc_c;
   logic signed [TW-1:0]   np_c;

   scsa_div #(
      .NUM_W (AVW),
      .DEN_W (DenW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_c),
      .mag   (mag_c),
      .den   (den_c),
      .done  (div_done),
      .quo   (div_quo)
   );

   // item classification
   always_comb begin
      fire_c = (state_ff == BK_IDLE) && item_valid && rsp_space;
      take_c = (item.op == OP_SAMPLE) && (sts_ff != STS_OFF) &&
               (code_ff == RC_TAKING) && (cnt_ff < CntW'(SAMPLES));
      last_c = (cnt_ff == CntW'(SAMPLES - 1));
      wr_c   = fire_c && take_c;
   end

   // arithmetic between registers
   always_comb begin
      v_raw_c = signed'({1'b0, nq_ff}) - VW'(ss_ff);
      bad_c   = ((BW'(v_ff) << 8) > BW'(dn_ff));
      nx_c    = rd_ff * $signed({1'b0, NConst});
      dev_c   = nx_c - DVW'(s_ff);
      ad_c    = dev_c[DVW-1] ? DVW'(-dev_c) : DVW'(dev_c);
      keep_c  = ((CMPW'(ad2_ff) << 16) < CMPW'(kv_ff));
      kh_c    = VW'(k2_ff) * VW'(v_ff[VW-1:24]);
   end

   // rounded average set-up and result
   always_comb begin
      if (kcnt_ff == '0) begin
         avg_sum_c = s_ff;
         avg_cnt_c = CntW'(SAMPLES);
      end else begin
         avg_sum_c = ksum_ff;
         avg_cnt_c = kcnt_ff;
      end
      den_c  = {avg_cnt_c, 1'b0};
      num_c  = (AVW'(avg_sum_c) <<< 9) + signed'(AVW'(avg_cnt_c));
      mag_c  = num_c[AVW-1] ? (AVW'(-num_c) + AVW'(den_c) - 1'b1) : AVW'(num_c);
      t_c    = neg_ff ? TW'(-div_quo) : TW'(div_quo);
      disc_c = {disc_thr, 8'd0};
      np_c   = {np_thr, 8'd0};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (fire_c && take_c && last_c) state_in = BK_SUM_RD;
         end
         BK_SUM_RD:  state_in = BK_SUM_SQ;
         BK_SUM_SQ:  state_in = BK_SUM_ACC;
         BK_SUM_ACC: state_in = (idx_ff == LastIdx) ? BK_VAR_A : BK_SUM_RD;
         BK_VAR_A:   state_in = BK_VAR_B;
         BK_VAR_B:   state_in = BK_BAD_CHK;
         BK_BAD_CHK: state_in = bad_c ? BK_DONE : BK_KV_LO;
         BK_KV_LO:   state_in = BK_KV_HI;
         BK_KV_HI:   state_in = BK_KEEP_RD;
         BK_KEEP_RD: state_in = BK_KEEP_DEV;
         BK_KEEP_DEV: state_in = BK_KEEP_SQ;
         BK_KEEP_SQ: state_in = BK_KEEP_CMP;
         BK_KEEP_CMP: state_in = (idx_ff == LastIdx) ? BK_AVG : BK_KEEP_RD;
         BK_AVG:     state_in = BK_DIV;
         BK_DIV: begin
            if (div_done) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (rsp_space) state_in = BK_IDLE;
         end
         default:    state_in = BK_IDLE;
      endcase
   end

   // outputs and sensor state updates
   always_comb begin
      cnt_in      = cnt_ff;
      sts_in      = sts_ff;
      code_in     = code_ff;
      temp_in     = temp_ff;
      item_pop    = 1'b0;
      rsp_push    = 1'b0;
      div_start_c = 1'b0;
      rsp.status  = sts_ff;
      rsp.code    = code_ff;
      rsp.temp    = temp_ff;
      rsp.done    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (fire_c) begin
               item_pop = 1'b1;
               case (item.op)
                  OP_START: begin
                     cnt_in  = '0;
                     code_in = RC_TAKING;
                  end
                  OP_POWER_ON:  sts_in = STS_NO_DATA;
                  OP_POWER_OFF: sts_in = STS_OFF;
                  default: begin
                     if (take_c) cnt_in = cnt_ff + 1'b1;
                  end
               endcase
               rsp_push   = !(take_c && last_c);
               rsp.status = sts_in;
               rsp.code   = code_in;
            end
         end
         BK_BAD_CHK: begin
            if (bad_c) begin
               sts_in  = STS_ERROR;
               code_in = RC_BAD;
            end
         end
         BK_AVG: div_start_c = 1'b1;
         BK_DIV: begin
            if (div_done) begin
               temp_in = t_c;
               if (t_c > disc_c) begin
                  sts_in  = STS_ERROR;
                  code_in = RC_DISCONNECTED;
               end else if (t_c < np_c) begin
                  sts_in  = STS_ERROR;
                  code_in = RC_NO_POWER;
               end else begin
                  sts_in  = STS_HAS_DATA;
                  code_in = RC_IDLE;
               end
            end
         end
         BK_DONE: begin
            rsp_push = rsp_space;
            rsp.done = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff   <= '0;
         sts_ff   <= STS_OFF;
         code_ff  <= RC_IDLE;
         temp_ff  <= TempReset;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sts_ff   <= sts_in;
         code_ff  <= code_in;
         temp_ff  <= temp_in;
      end
   end

   // sample store, registered read
   always_ff @(posedge clock) begin
      if (wr_c) store_ff[cnt_ff[AddrW-1:0]] <= item.x;
      rd_ff <= store_ff[idx_ff];
   end

   // reading datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            idx_ff <= '0;
            s_ff   <= '0;
            q_ff   <= '0;
         end
         BK_SUM_SQ: begin
            sq_ff <= rd_ff * rd_ff;
            s_ff  <= s_ff + SW'(rd_ff);
         end
         BK_SUM_ACC: begin
            q_ff   <= q_ff + QW'(sq_ff);
            idx_ff <= idx_ff + 1'b1;
         end
         BK_VAR_A: begin
            ss_ff <= s_ff * s_ff;
            nq_ff <= NQW'(q_ff) * NQW'(NConst);
            d2_ff <= 32'(max_dev) * 32'(max_dev);
            k2_ff <= 24'(sigma_scale) * 24'(sigma_scale);
         end
         BK_VAR_B: begin
            v_ff  <= v_raw_c[VW-1] ? '0 : VW'(v_raw_c);
            dn_ff <= DNW'(d2_ff) * DNW'(N2Const);
         end
         BK_KV_LO: kvlo_ff <= 48'(k2_ff) * 48'(v_ff[23:0]);
         BK_KV_HI: begin
            kv_ff   <= KVW'(kvlo_ff) + (KVW'(kh_c) << 24);
            idx_ff  <= '0;
            ksum_ff <= '0;
            kcnt_ff <= '0;
         end
         BK_KEEP_DEV: ad_ff <= ad_c;
         BK_KEEP_SQ:  ad2_ff <= (2*DVW)'(ad_ff) * (2*DVW)'(ad_ff);
         BK_KEEP_CMP: begin
            if (keep_c) begin
               ksum_ff <= ksum_ff + SW'(rd_ff);
               kcnt_ff <= kcnt_ff + 1'b1;
            end
            idx_ff <= idx_ff + 1'b1;
         end
         BK_AVG: neg_ff <= num_c[AVW-1];
         default: ;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/sigma_clipped_sensor_averager_unit.sv */
// Result path: an item that does not complete a reading has its result registered in
//   the input queue, then the result queue; one that completes a reading waits for
//   the two passes over the single-port sample store and the bit-serial divider.
// Throughput: one item per cycle while result queue has room and no reading completes.
// Reset: synchronous, active high; clears queues, sensor state and config registers.
// ----------------------------------------------------------------------------
// sigma_clipped_sensor_averager_unit
// One sensor channel: event handling, sample capture and sigma-clipped mean.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_clipped_sensor_averager_unit import scsa_pkg::*; #(
   parameter int SAMPLES_PER_READING = SamplesDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [1:0]           req_operation,
   input  wire logic [15:0]          req_adc_sample,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [1:0]                rsp_sensor_status,
   output logic [2:0]                rsp_reading_code,
   output logic signed [TW-1:0]      rsp_temperature_out,
   output logic                      rsp_reading_done,
   input  wire logic                 csr_write_enable,
   input  wire logic [CsrIdxW-1:0]   csr_index,
   input  wire logic [CsrDataW-1:0]  csr_write_data
);

   logic signed [15:0] offset_ff;
   logic [11:0]        sigma_ff;
   logic [15:0]        max_dev_ff;
   logic signed [17:0] disc_ff;
   logic signed [17:0] np_ff;

   logic     item_valid;
   item_type item;
   logic     item_pop;
   logic     bk_push;
   rsp_type  bk_rsp;
   logic     rsp_space;

   rsp_type    rq_ff [2];
   logic       rq_wr_ff;
   logic       rq_rd_ff;
   logic [1:0] rq_cnt_ff;
   logic       rq_pop_c;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= OffsetReset;
         sigma_ff   <= SigmaReset;
         max_dev_ff <= MaxDevReset;
         disc_ff    <= DiscReset;
         np_ff      <= NoPowerReset;
      end else if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_OFFSET:   offset_ff  <= csr_write_data[15:0];
            CSR_SIGMA:    sigma_ff   <= csr_write_data[11:0];
            CSR_MAX_DEV:  max_dev_ff <= csr_write_data[15:0];
            CSR_DISC:     disc_ff    <= csr_write_data;
            CSR_NO_POWER: np_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   scsa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_operation  (req_operation),
      .req_adc_sample (req_adc_sample),
      .offset         (offset_ff),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   scsa_back #(
      .SAMPLES (SAMPLES_PER_READING)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .rsp_space   (rsp_space),
      .rsp_push    (bk_push),
      .rsp         (bk_rsp),
      .sigma_scale (sigma_ff),
      .max_dev     (max_dev_ff),
      .disc_thr    (disc_ff),
      .np_thr      (np_ff)
   );

   // result queue
   assign rsp_space = (rq_cnt_ff != 2'd2);
   assign rsp_empty = (rq_cnt_ff == 2'd0);
   assign rq_pop_c  = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         if (bk_push)  rq_wr_ff <= !rq_wr_ff;
         if (rq_pop_c) rq_rd_ff <= !rq_rd_ff;
         rq_cnt_ff <= rq_cnt_ff + {1'b0, bk_push} - {1'b0, rq_pop_c};
      end
   end

   always_ff @(posedge clock) begin
      if (bk_push) rq_ff[rq_wr_ff] <= bk_rsp;
   end

   // head of the result queue
   assign rsp_sensor_status   = rq_ff[rq_rd_ff].status;
   assign rsp_reading_code    = rq_ff[rq_rd_ff].code;
   assign rsp_temperature_out = rq_ff[rq_rd_ff].temp;
   assign rsp_reading_done    = rq_ff[rq_rd_ff].done;

endmodule

`default_nettype wire

/* hdl/scsa_checker.sv */
// ----------------------------------------------------------------------------
// scsa_checker
// Port-level checks of the sensor averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scsa_checker import scsa_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_empty,
   input wire logic                 rsp_pop,
   input wire logic [1:0]           rsp_sensor_status,
   input wire logic [2:0]           rsp_reading_code,
   input wire logic signed [TW-1:0] rsp_temperature_out,
   input wire logic                 rsp_reading_done
);

   // result queue comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a waiting result and its temperature stay until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_temperature_out)))
      else $error("waiting result changed");

   // reading code stays in range
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_reading_code <= 3'd4))
      else $error("reading code out of range");

   // a completed reading leaves data or an error
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_reading_done) |->
      (rsp_sensor_status == STS_HAS_DATA || rsp_sensor_status == STS_ERROR))
      else $error("completed reading with wrong status");

   // good data from a completed reading comes with an idle code
   a_done_good: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_reading_done && rsp_sensor_status == STS_HAS_DATA) |->
      (rsp_reading_code == RC_IDLE))
      else $error("good reading with non-idle code");

endmodule

bind sigma_clipped_sensor_averager_unit scsa_checker u_scsa_checker (.*);

`default_nettype wire
